@@ rtl/periodic_task_timer_table_top_macros.svh @@
// assertion macros for the periodic timer table
// used by the top level only; no other dependencies
`ifndef PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ptt_pkg.sv @@
// shared types, codes and defaults for the periodic timer table
// no dependencies
`default_nettype none

package ptt_pkg;

    localparam int SLOTS_DEF      = 32;
    localparam int COUNT_BITS_DEF = 24;

    localparam int OP_W     = 2;
    localparam int PERIOD_W = 24;
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 24;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_REG   = 2'd0;
    localparam t_op OP_TICK  = 2'd1;
    localparam t_op OP_SLEEP = 2'd2;

    localparam t_kind KIND_REG   = 3'd0;
    localparam t_kind KIND_FULL  = 3'd1;
    localparam t_kind KIND_FIRED = 3'd2;
    localparam t_kind KIND_NONE  = 3'd3;
    localparam t_kind KIND_SLEEP = 3'd4;

    localparam t_cfg_idx CFG_RUN   = 1'b0;
    localparam t_cfg_idx CFG_SLEEP = 1'b1;

    localparam logic [CFG_W-1:0] RUN_RESET   = 24'd1000;
    localparam logic [CFG_W-1:0] SLEEP_RESET = 24'd4000;

endpackage

`default_nettype wire

@@ rtl/ptt_if.sv @@
// request, result and config channel interfaces for the timer table
// depends on ptt_pkg
`default_nettype none

interface ptt_in_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::OP_W-1:0]      op;
    logic [ptt_pkg::PERIOD_W-1:0]  period;
    modport source (output valid, output op, output period, input ready);
    modport sink   (input valid, input op, input period, output ready);
endinterface

interface ptt_out_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::KIND_W-1:0]    kind;
    logic [ptt_pkg::SLOT_W-1:0]    slot;
    logic                          last;
    modport source (output valid, output kind, output slot, output last, input ready);
    modport sink   (input valid, input kind, input slot, input last, output ready);
endinterface

interface ptt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::CFG_IDX_W-1:0] index;
    logic [ptt_pkg::CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/ptt_ram.sv @@
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/ptt_alu.sv @@
// shared subtract and compare unit for the timer table walk
// no dependencies
`default_nettype none

module ptt_alu #(
    parameter int W = 24
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_c,
    input  wire logic [W-1:0] i_d,
    output      logic [W-1:0] o_diff,
    output      logic         o_borrow,
    output      logic         o_gt
);

    logic [W:0] sub_ab;
    logic [W:0] sub_dc;

    // a - b with borrow out, and c > d as the borrow of d - c
    assign sub_ab   = {1'b0, i_a} - {1'b0, i_b};
    assign sub_dc   = {1'b0, i_d} - {1'b0, i_c};
    assign o_diff   = sub_ab[W-1:0];
    assign o_borrow = sub_ab[W];
    assign o_gt     = sub_dc[W];

endmodule

`default_nettype wire

@@ rtl/periodic_task_timer_table_top.sv @@
// periodic timer table top level: sequencer, slot memories, config registers
// depends on ptt_pkg, ptt_if, ptt_ram, ptt_alu and the assertion macro header
//
// Usage: requests arrive on i_in (op, period), results leave on o_out
// (kind, slot, last), config writes on i_cfg (index 0 run_ticks, index 1
// sleep_ticks; i_cfg.ready is always high, write only while idle).
// A register request writes the next free slot (none if the table is full)
// and gives one result from the finish state. A tick or sleep request walks
// the used slots one per cycle, unless a tick halts on a stalled o_out,
// through one shared subtract/compare unit, reading the countdown and period
// memories at one address per cycle and writing back the slot before;
// i_in.ready is high only while the sequencer is idle.
// Fired slots are held one deep so the final one can carry last; a result
// with nothing fired or a sleep result is a single item.
// If o_out is stalled the walk halts on the slot that needs to hand a result
// on, and resumes as soon as the output register frees.
// Reset clears the used count, the sequencer and the output register and
// loads run_ticks = 1000, sleep_ticks = 4000; slot memories are not cleared.
`default_nettype none

`include "periodic_task_timer_table_top_macros.svh"

module periodic_task_timer_table_top #(
    parameter int SLOTS      = ptt_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = ptt_pkg::COUNT_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptt_in_if.sink     i_in,
    ptt_out_if.source  o_out,
    ptt_cfg_if.sink    i_cfg
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW = $clog2(SLOTS + 1);
    localparam int CB = COUNT_BITS;
    localparam int AW = (COUNT_BITS > ptt_pkg::PERIOD_W) ? COUNT_BITS : ptt_pkg::PERIOD_W;
    localparam int SW = ptt_pkg::SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    // config registers
    logic [ptt_pkg::CFG_W-1:0] r_run_ticks;
    logic [ptt_pkg::CFG_W-1:0] r_sleep_ticks;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_ticks   <= ptt_pkg::RUN_RESET;
            r_sleep_ticks <= ptt_pkg::SLEEP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ptt_pkg::CFG_RUN:   r_run_ticks   <= i_cfg.data;
                ptt_pkg::CFG_SLEEP: r_sleep_ticks <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    t_state                r_state,      n_state;
    logic [UW-1:0]         r_used,       n_used;
    logic [IW-1:0]         r_idx,        n_idx;
    ptt_pkg::t_op          r_op,         n_op;
    ptt_pkg::t_kind        r_fin_kind,   n_fin_kind;
    logic [SW-1:0]         r_fin_slot,   n_fin_slot;
    logic                  r_pend_valid, n_pend_valid;
    logic [SW-1:0]         r_pend_slot,  n_pend_slot;
    logic                  r_out_valid,  n_out_valid;
    ptt_pkg::t_kind        r_out_kind,   n_out_kind;
    logic [SW-1:0]         r_out_slot,   n_out_slot;
    logic                  r_out_last,   n_out_last;

    // memory ports
    logic          cd_we;
    logic [IW-1:0] cd_waddr;
    logic [CB-1:0] cd_wdata;
    logic          rl_we;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [CB-1:0] rd_cd;
    logic [CB-1:0] rd_rl;

    // shared unit
    logic [AW-1:0] alu_b;
    logic [AW-1:0] alu_diff;
    logic          alu_borrow;
    logic          alu_gt;

    logic          in_acc;
    logic          out_free;
    logic          full;
    logic          last_slot;
    logic [CB-1:0] period_c;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign full      = (r_used >= UW'(SLOTS));
    assign last_slot = ((UW'(r_idx) + UW'(1)) == r_used);
    assign period_c  = CB'(i_in.period);
    assign alu_b     = (r_op == ptt_pkg::OP_TICK) ? AW'(1) : AW'(r_sleep_ticks);

    ptt_ram #(
        .WIDTH (CB),
        .DEPTH (SLOTS)
    ) u_cd_ram (
        .i_clk   (i_clk),
        .i_we    (cd_we),
        .i_waddr (cd_waddr),
        .i_wdata (cd_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_cd)
    );

    ptt_ram #(
        .WIDTH (CB),
        .DEPTH (SLOTS)
    ) u_rl_ram (
        .i_clk   (i_clk),
        .i_we    (rl_we),
        .i_waddr (r_used[IW-1:0]),
        .i_wdata (period_c),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_rl)
    );

    ptt_alu #(
        .W (AW)
    ) u_alu (
        .i_a      (AW'(rd_cd)),
        .i_b      (alu_b),
        .i_c      (AW'(rd_rl)),
        .i_d      (AW'(r_run_ticks)),
        .o_diff   (alu_diff),
        .o_borrow (alu_borrow),
        .o_gt     (alu_gt)
    );

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_idx        = r_idx;
        n_op         = r_op;
        n_fin_kind   = r_fin_kind;
        n_fin_slot   = r_fin_slot;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        cd_we        = 1'b0;
        cd_waddr     = r_idx;
        cd_wdata     = CB'(rd_rl);
        rl_we        = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = r_idx + IW'(1);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op         = i_in.op;
                    n_idx        = '0;
                    n_pend_valid = 1'b0;
                    n_fin_slot   = '0;
                    case (i_in.op)
                        ptt_pkg::OP_REG: begin
                            n_state = S_FIN;
                            if (full) begin
                                n_fin_kind = ptt_pkg::KIND_FULL;
                            end else begin
                                n_fin_kind = ptt_pkg::KIND_REG;
                                n_fin_slot = SW'(r_used);
                                cd_we      = 1'b1;
                                cd_waddr   = r_used[IW-1:0];
                                cd_wdata   = period_c;
                                rl_we      = 1'b1;
                                n_used     = r_used + UW'(1);
                            end
                        end
                        ptt_pkg::OP_TICK, ptt_pkg::OP_SLEEP: begin
                            n_fin_kind = (i_in.op == ptt_pkg::OP_TICK) ?
                                         ptt_pkg::KIND_NONE : ptt_pkg::KIND_SLEEP;
                            if (r_used == '0) begin
                                n_state = S_FIN;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_state   = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // tick: borrow means countdown was zero, so the slot fires
                if (r_op == ptt_pkg::OP_TICK) begin
                    if (!(alu_borrow && r_pend_valid && !out_free)) begin
                        cd_we    = 1'b1;
                        cd_wdata = alu_borrow ? rd_rl : CB'(alu_diff);
                        if (alu_borrow) begin
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = ptt_pkg::KIND_FIRED;
                                n_out_slot  = r_pend_slot;
                                n_out_last  = 1'b0;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_slot  = SW'(r_idx);
                        end
                        if (last_slot) begin
                            n_state = S_FIN;
                        end else begin
                            n_idx  = r_idx + IW'(1);
                            mem_re = 1'b1;
                        end
                    end
                end else begin
                    if (alu_gt) begin
                        cd_we    = 1'b1;
                        cd_wdata = alu_borrow ? '0 : CB'(alu_diff);
                    end
                    if (last_slot) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx  = r_idx + IW'(1);
                        mem_re = 1'b1;
                    end
                end
            end

            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_valid ? ptt_pkg::KIND_FIRED : r_fin_kind;
                    n_out_slot   = r_pend_valid ? r_pend_slot : r_fin_slot;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_op        <= n_op;
        r_fin_kind  <= n_fin_kind;
        r_fin_slot  <= n_fin_slot;
        r_pend_slot <= n_pend_slot;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.kind  = r_out_kind;
    assign o_out.slot  = r_out_slot;
    assign o_out.last  = r_out_last;

    `PTT_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= UW'(SLOTS), "used count above slot count")
    `PTT_ASSERT_NOW(a_walk_in_range, i_clk, i_rst_n, r_state == S_WALK, UW'(r_idx) < r_used, "walk index past used slots")
    `PTT_ASSERT_NEXT(a_reg_grows, i_clk, i_rst_n, in_acc && i_in.op == ptt_pkg::OP_REG && !full, r_used == $past(r_used) + UW'(1), "register request did not take a slot")
    `PTT_ASSERT_NOW(a_pend_tick_only, i_clk, i_rst_n, r_pend_valid, r_op == ptt_pkg::OP_TICK, "fired slot held outside a tick")

endmodule

`default_nettype wire

@@ bench/tb_periodic_task_timer_table_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for periodic_task_timer_table_top: drives register, tick and sleep
// requests, predicts every result from its own timer table copy; needs ptt_pkg, ptt_if, rtl

module tb_periodic_task_timer_table_top;

    localparam int SLOTS        = ptt_pkg::SLOTS_DEF;
    localparam int CNT_W        = ptt_pkg::COUNT_BITS_DEF;
    localparam int PERIOD_W     = ptt_pkg::PERIOD_W;
    localparam int SLOT_W       = ptt_pkg::SLOT_W;
    localparam int CFG_W        = ptt_pkg::CFG_W;
    localparam int DRAIN_CYCLES = SLOTS + 8;
    localparam int LIMIT_CYCLES = 500000;

    // op code the block ignores
    localparam ptt_pkg::t_op OP_UNUSED = 2'd3;

    typedef struct packed {
        ptt_pkg::t_kind    kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_timer_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ptt_in_if  in_ch ();
    ptt_out_if out_ch ();
    ptt_cfg_if cfg_ch ();

    periodic_task_timer_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted timer table
    logic [CNT_W-1:0] tbl_reload [SLOTS];
    logic [CNT_W-1:0] tbl_count  [SLOTS];
    int               tbl_used;
    logic [CFG_W-1:0] run_ticks;
    logic [CFG_W-1:0] sleep_ticks;

    t_timer_result pending_results[$];

    bit throttle_on;
    int stall_left;
    int fail_count;
    int cycle_count;
    int n_requests;
    int n_results;
    int n_fired;
    int n_full;
    int n_sleeps;

    task automatic expect_result(input ptt_pkg::t_kind kind, input int slot, input logic last);
        t_timer_result r;
        r.kind = kind;
        r.slot = SLOT_W'(slot);
        r.last = last;
        pending_results.push_back(r);
    endtask

    task automatic timer_table_predict(input ptt_pkg::t_op op,
                                       input logic [PERIOD_W-1:0] period);
        logic [SLOTS-1:0] fired_mask;
        int               last_fired;
        fired_mask = '0;
        last_fired = -1;
        case (op)
            ptt_pkg::OP_REG: begin
                if (tbl_used >= SLOTS) begin
                    expect_result(ptt_pkg::KIND_FULL, 0, 1'b1);
                    n_full++;
                end else begin
                    tbl_reload[tbl_used] = period;
                    tbl_count[tbl_used]  = period;
                    expect_result(ptt_pkg::KIND_REG, tbl_used, 1'b1);
                    tbl_used++;
                end
            end
            ptt_pkg::OP_TICK: begin
                for (int i = 0; i < tbl_used; i++) begin
                    if (tbl_count[i] != '0) begin
                        tbl_count[i] = tbl_count[i] - 1'b1;
                    end else begin
                        tbl_count[i]  = tbl_reload[i];
                        fired_mask[i] = 1'b1;
                        last_fired    = i;
                    end
                end
                if (last_fired < 0) begin
                    expect_result(ptt_pkg::KIND_NONE, 0, 1'b1);
                end else begin
                    for (int i = 0; i <= last_fired; i++) begin
                        if (fired_mask[i]) begin
                            expect_result(ptt_pkg::KIND_FIRED, i, i == last_fired);
                            n_fired++;
                        end
                    end
                end
            end
            ptt_pkg::OP_SLEEP: begin
                for (int i = 0; i < tbl_used; i++) begin
                    if (tbl_reload[i] > run_ticks) begin
                        if (tbl_count[i] > sleep_ticks)
                            tbl_count[i] = tbl_count[i] - sleep_ticks;
                        else
                            tbl_count[i] = '0;
                    end
                end
                expect_result(ptt_pkg::KIND_SLEEP, 0, 1'b1);
                n_sleeps++;
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input ptt_pkg::t_op op, input logic [PERIOD_W-1:0] period);
        if (throttle_on && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.op     <= op;
        in_ch.period <= period;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        timer_table_predict(op, period);
        n_requests++;
    endtask

    // let every outstanding result drain, then give the walk time to finish
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timer_config(input logic [CFG_W-1:0] run_val,
                                      input logic [CFG_W-1:0] sleep_val);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= ptt_pkg::CFG_RUN;
        cfg_ch.data  <= run_val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        run_ticks    = run_val;
        cfg_ch.index <= ptt_pkg::CFG_SLEEP;
        cfg_ch.data  <= sleep_val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sleep_ticks  = sleep_val;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [PERIOD_W-1:0] random_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return PERIOD_W'($urandom_range(0, 12));
        else if (r == 6)
            return PERIOD_W'($urandom_range(990, 1010));
        else if (r == 7)
            return $urandom_range(0, 1) ? {PERIOD_W{1'b1}} : '0;
        return PERIOD_W'($urandom);
    endfunction

    task automatic run_traffic(input int n_items);
        int           r;
        ptt_pkg::t_op op;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                op = ptt_pkg::OP_REG;
            else if (r < 75)
                op = ptt_pkg::OP_TICK;
            else if (r < 93)
                op = ptt_pkg::OP_SLEEP;
            else
                op = OP_UNUSED;
            send_request(op, random_period());
        end
    endtask

    task automatic test_empty_table();
        send_request(ptt_pkg::OP_TICK, '0);
        send_request(ptt_pkg::OP_SLEEP, '0);
        send_request(OP_UNUSED, {PERIOD_W{1'b1}});
        send_request(ptt_pkg::OP_TICK, {PERIOD_W{1'b1}});
    endtask

    task automatic test_register_and_fire();
        send_request(ptt_pkg::OP_REG, '0);
        send_request(ptt_pkg::OP_REG, {PERIOD_W{1'b1}});
        send_request(ptt_pkg::OP_REG, 24'd1);
        send_request(ptt_pkg::OP_TICK, '0);
        send_request(ptt_pkg::OP_TICK, '0);
        send_request(ptt_pkg::OP_REG, 24'd5000);
        send_request(ptt_pkg::OP_REG, 24'd1001);
        send_request(ptt_pkg::OP_REG, 24'd1000);
    endtask

    // reset values of run_ticks and sleep_ticks still in place here
    task automatic test_sleep_defaults();
        send_request(ptt_pkg::OP_SLEEP, '0);
        send_request(ptt_pkg::OP_TICK, '0);
        send_request(ptt_pkg::OP_SLEEP, {PERIOD_W{1'b1}});
        send_request(ptt_pkg::OP_TICK, '0);
    endtask

    task automatic test_random_traffic();
        write_timer_config(24'd4, 24'd3);
        run_traffic(100);
    endtask

    // fill the rest of the table, then two requests that find it full and a tick
    task automatic test_fill_table();
        while (tbl_used < SLOTS)
            send_request(ptt_pkg::OP_REG, PERIOD_W'($urandom_range(0, 20)));
        send_request(ptt_pkg::OP_REG, random_period());
        send_request(ptt_pkg::OP_REG, random_period());
        send_request(ptt_pkg::OP_TICK, '0);
    endtask

    task automatic test_config_extremes();
        write_timer_config('0, {CFG_W{1'b1}});
        run_traffic(90);
        write_timer_config({CFG_W{1'b1}}, '0);
        run_traffic(70);
    endtask

    task automatic test_unthrottled();
        write_timer_config(CFG_W'($urandom_range(0, 20)),
                           CFG_W'($urandom_range(1, 10)));
        throttle_on = 1'b0;
        run_traffic(110);
    endtask

    // result checker and output stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result kind %0d slot %0d last %0d",
                             $time, out_ch.kind, out_ch.slot, out_ch.last);
                    fail_count++;
                end else begin
                    automatic t_timer_result exp_r = pending_results.pop_front();
                    if (out_ch.kind !== exp_r.kind) begin
                        $display("%0t: kind mismatch, expected %0d actual %0d",
                                 $time, exp_r.kind, out_ch.kind);
                        fail_count++;
                    end
                    if (out_ch.slot !== exp_r.slot) begin
                        $display("%0t: slot mismatch, expected %0d actual %0d",
                                 $time, exp_r.slot, out_ch.slot);
                        fail_count++;
                    end
                    if (out_ch.last !== exp_r.last) begin
                        $display("%0t: last mismatch, expected %0d actual %0d",
                                 $time, exp_r.last, out_ch.last);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (throttle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("periodic_task_timer_table_top verification failed");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.op     = ptt_pkg::OP_REG;
        in_ch.period = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ptt_pkg::CFG_RUN;
        cfg_ch.data  = '0;
        throttle_on  = 1'b1;
        fail_count   = 0;
        n_requests   = 0;
        n_results    = 0;
        n_fired      = 0;
        n_full       = 0;
        n_sleeps     = 0;
        tbl_used     = 0;
        run_ticks    = ptt_pkg::RUN_RESET;
        sleep_ticks  = ptt_pkg::SLEEP_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_register_and_fire();
        test_sleep_defaults();
        test_random_traffic();
        test_fill_table();
        test_config_extremes();
        test_unthrottled();
        wait_idle();

        $display("ran %0d requests and checked %0d results: %0d slot firings, %0d sleeps,",
                 n_requests, n_results, n_fired, n_sleeps);
        $display("%0d full-table reports, %0d slots in use at the end",
                 n_full, tbl_used);
        if (fail_count == 0)
            $display("periodic_task_timer_table_top verification clean");
        else
            $display("periodic_task_timer_table_top verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_if.sv
rtl/ptt_ram.sv
rtl/ptt_alu.sv
rtl/periodic_task_timer_table_top.sv
bench/tb_periodic_task_timer_table_top.sv
